>>> src/rdm_discovery_responder_defines.svh
// Assertion macros for the RDM discovery responder.
// Included by every RTL file that carries concurrent assertions; no dependencies.
`ifndef RDM_DISCOVERY_RESPONDER_DEFINES_SVH
`define RDM_DISCOVERY_RESPONDER_DEFINES_SVH

`ifndef SYNTHESIS

// Implication that must hold at every clock edge outside reset.
`define RDM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rdm assertion failed");

// Condition that must never be true outside reset.
`define RDM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `RDM_ASSERT(lbl, clk, rst_n, !(cond))

`else

`define RDM_ASSERT(lbl, clk, rst_n, prop)
`define RDM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> src/rdm_pkg.sv
// Shared types and constants of the RDM discovery responder.
// No dependencies; used by the request channel interface and every module.
`timescale 1ns / 1ps

package rdm_pkg;

  // UID width and the broadcast UID.
  localparam int unsigned        RDM_UID_W     = 48;
  localparam logic [RDM_UID_W-1:0] RDM_UID_BCAST = '1;

  // Reply framing defaults.
  localparam int unsigned RDM_PREAMBLE_BYTES = 7;
  localparam int unsigned RDM_QUEUE_DEPTH    = 2;
  localparam int unsigned RDM_UID_BYTES      = 6;

  // Encoding constants.
  localparam logic [7:0] RDM_PREAMBLE  = 8'hFE;
  localparam logic [7:0] RDM_SEPARATOR = 8'hAA;
  localparam logic [7:0] RDM_MASK_AA   = 8'hAA;
  localparam logic [7:0] RDM_MASK_55   = 8'h55;

  // Request command codes; the remaining code is ignored.
  typedef enum logic [1:0] {
    CMD_UNIQUE_BRANCH = 2'd0,
    CMD_MUTE          = 2'd1,
    CMD_UNMUTE        = 2'd2
  } rdm_cmd_e;

  // One reply job handed from the front part to the back part.
  typedef struct packed {
    logic [RDM_UID_W-1:0] uid;
  } rdm_job_t;

endpackage

>>> src/rdm_req_if.sv
// Request channel: one decoded discovery request per word.
// Depends on rdm_pkg.
`timescale 1ns / 1ps

interface rdm_req_if
  import rdm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic [RDM_UID_W-1:0] dest_uid;
  logic [RDM_UID_W-1:0] lower_uid;
  logic [RDM_UID_W-1:0] upper_uid;

  modport source (
    output valid, command, dest_uid, lower_uid, upper_uid,
    input  ready
  );

  modport sink (
    input  valid, command, dest_uid, lower_uid, upper_uid,
    output ready
  );
endinterface

>>> src/rdm_byte_if.sv
// Reply channel: one encoded reply byte with its last mark per word.
// No dependencies.
`timescale 1ns / 1ps

interface rdm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (
    output valid, tx_byte, last_byte,
    input  ready
  );

  modport sink (
    input  valid, tx_byte, last_byte,
    output ready
  );
endinterface

>>> src/rdm_discovery_responder.sv
// Top level of the RDM discovery responder: device UID register, front part,
// job queue and back part. Depends on rdm_pkg, both channel interfaces and
// rdm_front, rdm_fifo, rdm_back.
//
//   Channel   Dir  Handshake      Word
//   req_i     in   valid/ready    command, dest_uid, lower_uid, upper_uid
//   rsp_o     out  valid/ready    tx_byte, last_byte
//   cfg       in   cfg_we_i       cfg_wdata_i = device UID
//
// A request is decoded in the cycle it is accepted; a matching unique-branch
// request queues a job, and the back part sends PreambleBytes + 17 bytes
// (24 by default) at one byte per cycle, while the receiver is ready, through its output register.
// Replies follow each other without a gap; the byte serializer sets the rate.
// Requests are taken every cycle while the job queue has room.
// Reset clears the mute flag, the device UID, the queue and the serializer.
`timescale 1ns / 1ps

module rdm_discovery_responder
  import rdm_pkg::*;
#(
  parameter int unsigned PreambleBytes = RDM_PREAMBLE_BYTES,
  parameter int unsigned QueueDepth    = RDM_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RDM_UID_W-1:0] cfg_wdata_i,
  rdm_req_if.sink              req_i,
  rdm_byte_if.source           rsp_o
);

  logic [RDM_UID_W-1:0] dev_uid_q;
  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  rdm_job_t             push_job, pop_job;

  // Device UID register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_uid_q <= '0;
    end else if (cfg_we_i) begin
      dev_uid_q <= cfg_wdata_i;
    end
  end

  rdm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dev_uid_i   (dev_uid_q),
    .req_i       (req_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  rdm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  rdm_back #(
    .PreambleBytes (PreambleBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .rsp_o       (rsp_o)
  );

endmodule

>>> src/rdm_front.sv
// Front part: accepts requests, filters on destination, keeps the mute flag
// and issues reply jobs. Depends on rdm_pkg, rdm_req_if and the defines header.
`timescale 1ns / 1ps
`include "rdm_discovery_responder_defines.svh"

module rdm_front
  import rdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RDM_UID_W-1:0] dev_uid_i,
  rdm_req_if.sink              req_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output rdm_job_t             job_o
);

  logic muted_q, muted_d;
  logic accept;
  logic addressed;
  logic in_branch;

  // A request is taken whenever the job queue has room.
  assign req_i.ready = job_ready_i;
  assign accept      = req_i.valid && job_ready_i;

  // Destination filter and branch range check.
  assign addressed = (req_i.dest_uid == dev_uid_i) || (req_i.dest_uid == RDM_UID_BCAST);
  assign in_branch = (req_i.lower_uid <= dev_uid_i) && (dev_uid_i <= req_i.upper_uid);

  // Command decode.
  always_comb begin
    muted_d     = muted_q;
    job_valid_o = 1'b0;
    if (accept && addressed) begin
      case (req_i.command)
        CMD_UNIQUE_BRANCH: job_valid_o = !muted_q && in_branch;
        CMD_MUTE:          muted_d = 1'b1;
        CMD_UNMUTE:        muted_d = 1'b0;
        default:           muted_d = muted_q;
      endcase
    end
  end

  assign job_o.uid = dev_uid_i;

  // Mute flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      muted_q <= 1'b0;
    end else begin
      muted_q <= muted_d;
    end
  end

  // The mute flag only moves on an accepted request.
  `RDM_ASSERT(a_mute_on_accept, clk_i, rst_ni, !accept |=> $stable(muted_q))

endmodule

>>> src/rdm_fifo.sv
// Short job queue between the front and back parts.
// Depends on rdm_pkg and the defines header.
`timescale 1ns / 1ps
`include "rdm_discovery_responder_defines.svh"

module rdm_fifo
  import rdm_pkg::*;
#(
  parameter int unsigned Depth = RDM_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  rdm_job_t push_job_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output rdm_job_t pop_job_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rdm_job_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Read and write pointers agree whenever the queue is empty.
  `RDM_ASSERT(a_empty_ptrs, clk_i, rst_ni, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

>>> src/rdm_back.sv
// Back part: serializes one reply per job, one byte per cycle while the receiver
// is ready, with a running checksum and an output register. Depends on rdm_pkg,
// rdm_byte_if and the defines header.
`timescale 1ns / 1ps
`include "rdm_discovery_responder_defines.svh"

module rdm_back
  import rdm_pkg::*;
#(
  parameter int unsigned PreambleBytes = RDM_PREAMBLE_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  rdm_job_t  job_i,
  rdm_byte_if.source rsp_o
);

  localparam int unsigned ReplyLen = PreambleBytes + 17;
  localparam int unsigned IdxW     = $clog2(ReplyLen);

  localparam logic [IdxW-1:0] SepIdx   = IdxW'(PreambleBytes);
  localparam logic [IdxW-1:0] UidFirst = IdxW'(PreambleBytes + 1);
  localparam logic [IdxW-1:0] CsFirst  = IdxW'(PreambleBytes + 13);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(ReplyLen - 1);

  logic                 busy_q;
  logic [IdxW-1:0]      idx_q;
  logic [RDM_UID_W-1:0] uid_q;
  logic [15:0]          sum_q, sum_d;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;

  logic                 adv;
  logic                 at_last;
  logic                 start;
  logic [IdxW-1:0]      uid_off;
  logic [IdxW-1:0]      cs_off;
  logic [7:0]           uid_byte;
  logic [7:0]           src_byte;
  logic [7:0]           cur_byte;
  logic                 is_uid;

  // A byte moves into the output register whenever that register frees up.
  assign adv     = busy_q && (!out_valid_q || rsp_o.ready);
  assign at_last = (idx_q == LastIdx);
  assign start   = job_valid_i && (!busy_q || (adv && at_last));
  assign job_ready_o = start;

  assign uid_off = idx_q - UidFirst;
  assign cs_off  = idx_q - CsFirst;

  // UID byte, most significant first.
  always_comb begin
    case (uid_off[3:1])
      3'd0:    uid_byte = uid_q[47:40];
      3'd1:    uid_byte = uid_q[39:32];
      3'd2:    uid_byte = uid_q[31:24];
      3'd3:    uid_byte = uid_q[23:16];
      3'd4:    uid_byte = uid_q[15:8];
      3'd5:    uid_byte = uid_q[7:0];
      default: uid_byte = '0;
    endcase
  end

  // Byte for the current position of the reply.
  always_comb begin
    is_uid   = 1'b0;
    src_byte = '0;
    cur_byte = RDM_PREAMBLE;
    if (idx_q < SepIdx) begin
      cur_byte = RDM_PREAMBLE;
    end else if (idx_q == SepIdx) begin
      cur_byte = RDM_SEPARATOR;
    end else if (idx_q < CsFirst) begin
      is_uid   = 1'b1;
      cur_byte = uid_byte | (uid_off[0] ? RDM_MASK_55 : RDM_MASK_AA);
    end else begin
      src_byte = cs_off[1] ? sum_q[7:0] : sum_q[15:8];
      cur_byte = src_byte | (cs_off[0] ? RDM_MASK_55 : RDM_MASK_AA);
    end
  end

  // Running checksum over the encoded UID bytes.
  assign sum_d = (adv && is_uid) ? sum_q + {8'h00, cur_byte} : sum_q;

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (adv) begin
      if (at_last) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Job payload and checksum.
  always_ff @(posedge clk_i) begin
    if (start) begin
      uid_q <= job_i.uid;
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= cur_byte;
      out_last_q <= at_last;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.tx_byte   = out_byte_q;
  assign rsp_o.last_byte = out_last_q;

  // A new reply always begins at the first position with a clear checksum.
  `RDM_ASSERT(a_start_clear, clk_i, rst_ni, start |=> (idx_q == '0) && (sum_q == '0) && busy_q)
  // The position counter never runs past the final byte.
  `RDM_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, idx_q > LastIdx)

endmodule

>>> sim/rdm_reply_checker.sv
// Reply checker for the RDM discovery responder: tracks the device UID and the
// mute flag, predicts each discovery reply and compares it word by word.
// Depends on rdm_pkg and the rdm_req_if / rdm_byte_if channel interfaces.
`timescale 1ns / 1ps

module rdm_reply_checker
  import rdm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [RDM_UID_W-1:0] cfg_wdata_i,
  rdm_req_if                   req_mon,
  rdm_byte_if                  rsp_mon,
  output int unsigned          err_cnt_o,
  output int unsigned          pend_cnt_o,
  output int unsigned          req_cnt_o,
  output int unsigned          byte_cnt_o
);

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } reply_word_t;

  reply_word_t          reply_bytes_q[$];
  logic [RDM_UID_W-1:0] dev_uid;
  logic                 is_muted;

  // Every mismatch prints one line and is counted.
  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt_o++;
  endtask

  // Queue the full unique-branch reply for the given device UID.
  function automatic void queue_branch_reply(logic [RDM_UID_W-1:0] uid);
    logic [15:0] sum;
    logic [7:0]  ub;
    logic [7:0]  enc_aa;
    logic [7:0]  enc_55;
    sum = '0;
    for (int i = 0; i < RDM_PREAMBLE_BYTES; i++) begin
      reply_bytes_q.push_back('{tx_byte: RDM_PREAMBLE, last_byte: 1'b0});
    end
    reply_bytes_q.push_back('{tx_byte: RDM_SEPARATOR, last_byte: 1'b0});
    for (int i = RDM_UID_BYTES - 1; i >= 0; i--) begin
      ub     = uid[8*i +: 8];
      enc_aa = ub | RDM_MASK_AA;
      enc_55 = ub | RDM_MASK_55;
      reply_bytes_q.push_back('{tx_byte: enc_aa, last_byte: 1'b0});
      reply_bytes_q.push_back('{tx_byte: enc_55, last_byte: 1'b0});
      sum = sum + {8'h00, enc_aa} + {8'h00, enc_55};
    end
    reply_bytes_q.push_back('{tx_byte: sum[15:8] | RDM_MASK_AA, last_byte: 1'b0});
    reply_bytes_q.push_back('{tx_byte: sum[15:8] | RDM_MASK_55, last_byte: 1'b0});
    reply_bytes_q.push_back('{tx_byte: sum[7:0] | RDM_MASK_AA, last_byte: 1'b0});
    reply_bytes_q.push_back('{tx_byte: sum[7:0] | RDM_MASK_55, last_byte: 1'b1});
  endfunction

  // Compare outgoing words first, then decode the accepted request, then take
  // a register write, so a request in the same cycle sees the old UID.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_word_t want;
    if (!rst_ni) begin
      reply_bytes_q.delete();
      dev_uid    = '0;
      is_muted   = 1'b0;
      err_cnt_o  = 0;
      pend_cnt_o = 0;
      req_cnt_o  = 0;
      byte_cnt_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        byte_cnt_o++;
        if (reply_bytes_q.size() == 0) begin
          flag_mismatch($sformatf("reply word %h/%b with nothing expected",
                                  rsp_mon.tx_byte, rsp_mon.last_byte));
        end else begin
          want = reply_bytes_q.pop_front();
          if (rsp_mon.tx_byte !== want.tx_byte) begin
            flag_mismatch($sformatf("tx_byte %h, expected %h",
                                    rsp_mon.tx_byte, want.tx_byte));
          end
          if (rsp_mon.last_byte !== want.last_byte) begin
            flag_mismatch($sformatf("last_byte %b, expected %b (tx_byte %h)",
                                    rsp_mon.last_byte, want.last_byte, want.tx_byte));
          end
        end
      end

      // Requests for another UID are dropped whatever the command.
      if (req_mon.valid && req_mon.ready) begin
        req_cnt_o++;
        if (req_mon.dest_uid == dev_uid || req_mon.dest_uid == RDM_UID_BCAST) begin
          case (req_mon.command)
            CMD_MUTE: begin
              is_muted = 1'b1;
            end
            CMD_UNMUTE: begin
              is_muted = 1'b0;
            end
            CMD_UNIQUE_BRANCH: begin
              if (!is_muted && req_mon.lower_uid <= dev_uid &&
                  req_mon.upper_uid >= dev_uid) begin
                queue_branch_reply(dev_uid);
              end
            end
            default: begin
            end
          endcase
        end
      end

      if (cfg_we_i) begin
        dev_uid = cfg_wdata_i;
      end
      pend_cnt_o = reply_bytes_q.size();
    end
  end

endmodule

>>> sim/rdm_discovery_responder_tb.sv
// Testbench top for the RDM discovery responder: clock, reset, request and
// register stimulus, random backpressure and the final verdict.
// Depends on rdm_pkg, both channel interfaces, the responder and rdm_reply_checker.
`timescale 1ns / 1ps

module rdm_discovery_responder_tb;
  import rdm_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 78;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [RDM_UID_W-1:0] cfg_wdata;
  logic                 calm;
  int unsigned          err_cnt;
  int unsigned          pend_cnt;
  int unsigned          req_cnt;
  int unsigned          byte_cnt;
  int unsigned          uid_settings;
  int unsigned          quiet_cycles;

  rdm_req_if  req ();
  rdm_byte_if rsp ();

  rdm_discovery_responder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  rdm_reply_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_mon    (req),
    .rsp_mon    (rsp),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt),
    .req_cnt_o  (req_cnt),
    .byte_cnt_o (byte_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [RDM_UID_W-1:0] rand_uid();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[RDM_UID_W-1:0];
  endfunction

  // Present one request word and hold it until the responder takes it.
  task automatic send_request(input logic [1:0] cmd, input logic [RDM_UID_W-1:0] dest,
                              input logic [RDM_UID_W-1:0] lo,
                              input logic [RDM_UID_W-1:0] hi);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid     = 1'b1;
    req.command   = cmd;
    req.dest_uid  = dest;
    req.lower_uid = lo;
    req.upper_uid = hi;
    do begin
      @(posedge clk_i);
    end while (!req.ready);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted reply byte has gone out.
  task automatic drain_replies();
    req.valid = 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_device_uid(input logic [RDM_UID_W-1:0] uid);
    drain_replies();
    cfg_we    = 1'b1;
    cfg_wdata = uid;
    @(negedge clk_i);
    cfg_we = 1'b0;
    uid_settings++;
  endtask

  // Mostly well-formed requests that reach this device, plus noise.
  task automatic send_random_request(input logic [RDM_UID_W-1:0] uid);
    int unsigned          pick;
    logic [1:0]           cmd;
    logic [RDM_UID_W-1:0] dest;
    logic [RDM_UID_W-1:0] lo;
    logic [RDM_UID_W-1:0] hi;
    pick = $urandom_range(0, 99);
    cmd  = CMD_UNIQUE_BRANCH;
    dest = ($urandom_range(0, 1) == 1) ? uid : RDM_UID_BCAST;
    lo   = rand_uid() & uid;
    hi   = rand_uid() | uid;
    if (pick < 8) begin
      cmd = CMD_MUTE;
    end else if (pick < 20) begin
      cmd = CMD_UNMUTE;
    end else if (pick < 28) begin
      lo = rand_uid();
      hi = rand_uid();
    end else if (pick < 34) begin
      dest = rand_uid();
      cmd  = ($urandom_range(0, 2) == 0) ? CMD_MUTE : CMD_UNIQUE_BRANCH;
    end else if (pick < 38) begin
      cmd = CMD_UNUSED;
    end
    send_request(cmd, dest, lo, hi);
  endtask

  // Reply side: ready with random stalls; no new stall starts while the run is calm.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp.ready = 1'b0;
        stall_left--;
      end else begin
        rsp.ready = 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [RDM_UID_W-1:0] uid;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    calm          = 1'b0;
    uid_settings  = 0;
    req.valid     = 1'b0;
    req.command   = CMD_UNIQUE_BRANCH;
    req.dest_uid  = '0;
    req.lower_uid = '0;
    req.upper_uid = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Device UID still at its reset value of zero.
    send_request(CMD_UNIQUE_BRANCH, RDM_UID_BCAST, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, '0, '0, RDM_UID_BCAST);

    // Directed checks around a mid-range UID.
    uid = 48'h1234_5678_9ABC;
    set_device_uid(uid);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, RDM_UID_BCAST);
    send_request(CMD_UNIQUE_BRANCH, RDM_UID_BCAST, uid, uid);
    send_request(CMD_UNIQUE_BRANCH, uid, uid + 1, RDM_UID_BCAST);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, uid - 1);
    // Inverted branch bounds hold no UID.
    send_request(CMD_UNIQUE_BRANCH, uid, RDM_UID_BCAST, '0);
    // Requests for a foreign UID are ignored, mute included.
    send_request(CMD_UNIQUE_BRANCH, '0, '0, RDM_UID_BCAST);
    send_request(CMD_MUTE, uid + 1, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, RDM_UID_BCAST);
    send_request(CMD_MUTE, uid, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, RDM_UID_BCAST);
    send_request(CMD_UNMUTE, uid - 1, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, RDM_UID_BCAST, '0, RDM_UID_BCAST);
    // Broadcast unmute and mute act like directed ones.
    send_request(CMD_UNMUTE, RDM_UID_BCAST, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, uid, uid, RDM_UID_BCAST);
    send_request(CMD_MUTE, RDM_UID_BCAST, '0, '0);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, uid);
    send_request(CMD_UNMUTE, uid, '0, '0);
    // The unused command code changes nothing.
    send_request(CMD_UNUSED, uid, '0, RDM_UID_BCAST);
    send_request(CMD_UNIQUE_BRANCH, uid, '0, RDM_UID_BCAST);

    // All-ones device UID coincides with the broadcast UID.
    set_device_uid(RDM_UID_BCAST);
    send_request(CMD_UNIQUE_BRANCH, RDM_UID_BCAST, RDM_UID_BCAST, RDM_UID_BCAST);
    send_request(CMD_UNIQUE_BRANCH, RDM_UID_BCAST, '0, RDM_UID_BCAST - 1);

    // Random phases, each under its own device UID.
    for (int p = 0; p < 5; p++) begin
      case (p)
        1:       uid = 48'h5555_AAAA_5555;
        2:       uid = '0;
        3:       uid = RDM_UID_BCAST;
        default: uid = rand_uid();
      endcase
      set_device_uid(uid);
      calm = (p == 1);
      repeat (PHASE_ITEMS) send_random_request(uid);
    end
    calm = 1'b0;

    drain_replies();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Sent %0d discovery requests and checked %0d reply bytes",
             req_cnt, byte_cnt);
    $display("across %0d device UID settings, with mute, broadcast and bound cases.",
             uid_settings);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> rdm_discovery_responder.f
+incdir+src
src/rdm_pkg.sv
src/rdm_req_if.sv
src/rdm_byte_if.sv
src/rdm_front.sv
src/rdm_fifo.sv
src/rdm_back.sv
src/rdm_discovery_responder.sv
sim/rdm_reply_checker.sv
sim/rdm_discovery_responder_tb.sv
